### rtl/core/cpi_pkg.sv
// Shared types and constants for the circle pair intersection unit.
`default_nettype none

package cpi_pkg;

	// Result kinds reported on the output stream.
	typedef enum logic [1:0] {
		OUT_APART     = 2'd0,
		OUT_CONTAINED = 2'd1,
		OUT_CROSSING  = 2'd2
	} outcome_t;

	// Widest operand slice that one hardware multiplier takes.
	localparam int unsigned MUL_CHUNK = 32;

endpackage

`default_nettype wire

### rtl/core/circle_pair_intersection_unit.sv
// Circle pair intersection unit: top level with the geometry pipeline and output skid.
// Takes one pair of circles per clock while the spare output entry is free and returns
// whether they lie apart, one inside the other, or cross, with the two crossing points
// rounded to nearest and saturated to the coordinate range. The square root resolves
// one root bit per stage behind an input register and the four dividers one quotient
// bit per stage behind theirs. Throughput is one pair per cycle while that entry is
// free; a stalled output is absorbed by a two-entry output buffer before the input
// side stops.
`default_nettype none

module circle_pair_intersection_unit #(
	parameter int unsigned COORD_WIDTH = 32
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  s_axis_tvalid,
	output logic       s_axis_tready,
	// first_center_x, first_center_y, first_radius, second_center_x,
	// second_center_y, second_radius; zero padding above.
	input  wire logic [((6*COORD_WIDTH-2+7)/8)*8-1:0] s_axis_tdata,
	output logic       m_axis_tvalid,
	input  wire logic  m_axis_tready,
	// point_a_x, point_a_y, point_b_x, point_b_y.
	output logic [((4*COORD_WIDTH+7)/8)*8-1:0] m_axis_tdata,
	// outcome.
	output logic [1:0] m_axis_tuser
);
	import cpi_pkg::*;

	localparam int unsigned CW      = COORD_WIDTH;
	localparam int unsigned RAD_W   = CW - 1;
	localparam int unsigned OUT_PAD = ((4*CW + 7) / 8) * 8;
	localparam int unsigned SQ_W    = 2 * CW;
	localparam int unsigned MAG_W   = 2 * RAD_W;
	localparam int unsigned D2_W    = 2 * CW + 1;
	localparam int unsigned QQ_W    = 4 * CW;
	localparam int unsigned RT_W    = 2 * CW;
	localparam int unsigned PR_W    = 3 * CW;
	localparam int unsigned MG_W    = 3 * CW + 1;
	localparam int unsigned NUM_W   = 3 * CW + 2;
	localparam int unsigned DEN_W   = 2 * CW + 2;

	typedef struct packed {
		outcome_t               outcome;
		logic signed [CW-1:0]   x0;
		logic signed [CW-1:0]   y0;
		logic [CW-1:0]          adx;
		logic [CW-1:0]          ady;
		logic                   negx;
		logic                   negy;
		logic                   kneg;
		logic [SQ_W-1:0]        km;
		logic [D2_W-1:0]        d2;
	} geo_t;

	typedef struct packed {
		outcome_t               outcome;
		logic signed [CW-1:0]   x0;
		logic signed [CW-1:0]   y0;
		logic                   neg;
	} dtag_t;

	logic adv;

	// Input unpacking.
	logic [CW-1:0]    in_x0, in_y0, in_x1, in_y1;
	logic [RAD_W-1:0] in_r0, in_r1;

	assign in_x0 = s_axis_tdata[CW-1:0];
	assign in_y0 = s_axis_tdata[2*CW-1:CW];
	assign in_r0 = s_axis_tdata[3*CW-2:2*CW];
	assign in_x1 = s_axis_tdata[4*CW-2:3*CW-1];
	assign in_y1 = s_axis_tdata[5*CW-2:4*CW-1];
	assign in_r1 = s_axis_tdata[6*CW-3:5*CW-1];

	// Stage registers.
	logic                  v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	logic                  v_s9, v_s10, v_s11, v_s12;
	logic signed [CW:0]    dx_s1, dy_s1;
	logic signed [CW-1:0]  x0_s1, y0_s1, x0_s2, y0_s2, x0_s3, y0_s3;
	logic signed [CW-1:0]  x0_s4, y0_s4, x0_s5, y0_s5, x0_s6, y0_s6, x0_s7, y0_s7;
	logic [RAD_W-1:0]      r0_s1, r1_s1, r0_s2, r1_s2, dr_s2;
	logic [CW:0]           adx_s2, ady_s2;
	logic [CW-1:0]         sum_s2;
	logic                  negx_s2, negy_s2, negx_s3, negy_s3, negx_s4, negy_s4;
	logic                  negx_s5, negy_s5, negx_s6, negy_s6, negx_s7, negy_s7;
	logic [CW-1:0]         adx_s3, ady_s3, adx_s4, ady_s4, adx_s5, ady_s5;
	logic [CW-1:0]         adx_s6, ady_s6, adx_s7, ady_s7;
	logic                  far_s3, far_s4, far_s5;
	logic [D2_W-1:0]       d2_s5, d2_s6, d2_s7;
	logic [SQ_W-1:0]       ssq_s5;
	logic [MAG_W-1:0]      drsq_s5, r0sq_s5, r1sq_s5;
	outcome_t              outcome_s6, outcome_s7;
	logic [SQ_W-1:0]       qa_s6, qb_s6;
	logic                  amb_neg_s6;
	logic [MAG_W-1:0]      amb_mag_s6;
	logic [SQ_W-1:0]       km_s7;
	logic                  kneg_s7;
	geo_t                  geo_s8, geo_s9, geo_s10;
	logic                  nax_s11, nay_s11, nbx_s11, nby_s11;
	logic [MG_W-1:0]       max_s11, may_s11, mbx_s11, mby_s11;
	outcome_t              outcome_s11, outcome_s12;
	logic signed [CW-1:0]  x0_s11, y0_s11, x0_s12, y0_s12;
	logic [D2_W-1:0]       d2_s11;
	logic                  nax_s12, nay_s12, nbx_s12, nby_s12;
	logic [NUM_W-1:0]      nax_num_s12, nay_num_s12, nbx_num_s12, nby_num_s12;
	logic [DEN_W-1:0]      den_s12;

	// Multiplier results.
	logic [SQ_W-1:0]   adxsq, adysq, sumsq;
	logic [MAG_W-1:0]  drsq, r0sq, r1sq;
	logic [QQ_W-1:0]   qq;
	logic [PR_W-1:0]   t1x, t1y, pp, qp;

	// Root and divider outputs.
	logic              sq_v;
	logic [RT_W-1:0]   sq_root;
	geo_t              sq_tag;
	logic              dv_v, dv1_v, dv2_v, dv3_v;
	logic [CW-1:0]     q_ax, q_ay, q_bx, q_by;
	logic              big_ax, big_ay, big_bx, big_by;
	dtag_t             dtag;
	logic              neg_ay, neg_bx, neg_by;

	// Output side.
	logic [OUT_PAD-1:0] res_data;
	logic [1:0]         res_user;
	logic               out_v_q, sk_v_q;
	logic [OUT_PAD-1:0] out_data_q, sk_data_q;
	logic [1:0]         out_user_q, sk_user_q;

	// The pipeline moves whenever the spare output entry is free.
	assign adv           = !sk_v_q;
	assign s_axis_tready = adv;

	function automatic logic [MG_W:0] sm_add(input logic na, input logic [PR_W-1:0] ma,
			input logic nb, input logic [PR_W-1:0] mb);
		logic [MG_W-1:0] ea;
		logic [MG_W-1:0] eb;
		ea = MG_W'(ma);
		eb = MG_W'(mb);
		if (na == nb) begin
			return {na, ea + eb};
		end else if (ea >= eb) begin
			return {na, ea - eb};
		end
		return {nb, eb - ea};
	endfunction

	function automatic logic [CW-1:0] place(input logic [CW-1:0] base, input logic neg,
			input logic ovf, input logic [CW-1:0] q);
		logic [CW+1:0] v;
		v = neg ? {{2{base[CW-1]}}, base} - {2'b00, q}
		        : {{2{base[CW-1]}}, base} + {2'b00, q};
		if (ovf) begin
			return neg ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
		end else if (v[CW+1:CW-1] != '0 && v[CW+1:CW-1] != '1) begin
			return v[CW+1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
		end
		return v[CW-1:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
			v_s12 <= 1'b0;
		end else if (adv) begin
			v_s1  <= s_axis_tvalid;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s4  <= v_s3;
			v_s5  <= v_s4;
			v_s6  <= v_s5;
			v_s7  <= v_s6;
			v_s8  <= v_s7;
			v_s9  <= sq_v;
			v_s10 <= v_s9;
			v_s11 <= v_s10;
			v_s12 <= v_s11;
		end
	end

	// Centre offsets, then magnitudes, radius sum and radius difference.
	always_ff @(posedge clk) begin
		if (adv) begin
			dx_s1   <= {in_x1[CW-1], in_x1} - {in_x0[CW-1], in_x0};
			dy_s1   <= {in_y1[CW-1], in_y1} - {in_y0[CW-1], in_y0};
			x0_s1   <= in_x0;
			y0_s1   <= in_y0;
			r0_s1   <= in_r0;
			r1_s1   <= in_r1;

			adx_s2  <= dx_s1[CW] ? (CW+1)'(-dx_s1) : (CW+1)'(dx_s1);
			ady_s2  <= dy_s1[CW] ? (CW+1)'(-dy_s1) : (CW+1)'(dy_s1);
			negx_s2 <= dx_s1[CW];
			negy_s2 <= dy_s1[CW];
			sum_s2  <= CW'(r0_s1) + CW'(r1_s1);
			dr_s2   <= (r0_s1 > r1_s1) ? r0_s1 - r1_s1 : r1_s1 - r0_s1;
			r0_s2   <= r0_s1;
			r1_s2   <= r1_s1;
			x0_s2   <= x0_s1;
			y0_s2   <= y0_s1;
		end
	end

	cpi_mul #(.A_W(CW), .B_W(CW)) u_mul_adx (
		.clk(clk), .en(adv), .a(adx_s2[CW-1:0]), .b(adx_s2[CW-1:0]), .p(adxsq));
	cpi_mul #(.A_W(CW), .B_W(CW)) u_mul_ady (
		.clk(clk), .en(adv), .a(ady_s2[CW-1:0]), .b(ady_s2[CW-1:0]), .p(adysq));
	cpi_mul #(.A_W(CW), .B_W(CW)) u_mul_sum (
		.clk(clk), .en(adv), .a(sum_s2), .b(sum_s2), .p(sumsq));
	cpi_mul #(.A_W(RAD_W), .B_W(RAD_W)) u_mul_dr (
		.clk(clk), .en(adv), .a(dr_s2), .b(dr_s2), .p(drsq));
	cpi_mul #(.A_W(RAD_W), .B_W(RAD_W)) u_mul_r0 (
		.clk(clk), .en(adv), .a(r0_s2), .b(r0_s2), .p(r0sq));
	cpi_mul #(.A_W(RAD_W), .B_W(RAD_W)) u_mul_r1 (
		.clk(clk), .en(adv), .a(r1_s2), .b(r1_s2), .p(r1sq));

	// An offset beyond the radius sum means apart, and keeps the squares
	// below from needing the extra bit.
	always_ff @(posedge clk) begin
		if (adv) begin
			far_s3  <= (adx_s2 > (CW+1)'(sum_s2)) || (ady_s2 > (CW+1)'(sum_s2));
			adx_s3  <= adx_s2[CW-1:0];
			ady_s3  <= ady_s2[CW-1:0];
			negx_s3 <= negx_s2;
			negy_s3 <= negy_s2;
			x0_s3   <= x0_s2;
			y0_s3   <= y0_s2;

			far_s4  <= far_s3;
			adx_s4  <= adx_s3;
			ady_s4  <= ady_s3;
			negx_s4 <= negx_s3;
			negy_s4 <= negy_s3;
			x0_s4   <= x0_s3;
			y0_s4   <= y0_s3;

			d2_s5   <= D2_W'(adxsq) + D2_W'(adysq);
			ssq_s5  <= sumsq;
			drsq_s5 <= drsq;
			r0sq_s5 <= r0sq;
			r1sq_s5 <= r1sq;
			far_s5  <= far_s4;
			adx_s5  <= adx_s4;
			ady_s5  <= ady_s4;
			negx_s5 <= negx_s4;
			negy_s5 <= negy_s4;
			x0_s5   <= x0_s4;
			y0_s5   <= y0_s4;
		end
	end

	// Classification, the two factors of the squared chord term and the
	// difference of the squared radii.
	always_ff @(posedge clk) begin
		if (adv) begin
			if (far_s5 || d2_s5 > D2_W'(ssq_s5)) begin
				outcome_s6 <= OUT_APART;
			end else if (d2_s5 <= D2_W'(drsq_s5)) begin
				outcome_s6 <= OUT_CONTAINED;
			end else begin
				outcome_s6 <= OUT_CROSSING;
			end
			qa_s6      <= SQ_W'(d2_s5 - D2_W'(drsq_s5));
			qb_s6      <= SQ_W'(D2_W'(ssq_s5) - d2_s5);
			amb_neg_s6 <= r0sq_s5 < r1sq_s5;
			amb_mag_s6 <= (r0sq_s5 < r1sq_s5) ? r1sq_s5 - r0sq_s5 : r0sq_s5 - r1sq_s5;
			d2_s6      <= d2_s5;
			adx_s6     <= adx_s5;
			ady_s6     <= ady_s5;
			negx_s6    <= negx_s5;
			negy_s6    <= negy_s5;
			x0_s6      <= x0_s5;
			y0_s6      <= y0_s5;
		end
	end

	cpi_mul #(.A_W(SQ_W), .B_W(SQ_W)) u_mul_qq (
		.clk(clk), .en(adv), .a(qa_s6), .b(qb_s6), .p(qq));

	// Signed 2*a*d held as sign and magnitude; only its low 2*COORD_WIDTH bits are used.
	logic [D2_W:0] km_full;
	logic          kneg_c;

	always_comb begin
		kneg_c = 1'b0;
		if (!amb_neg_s6) begin
			km_full = (D2_W+1)'(d2_s6) + (D2_W+1)'(amb_mag_s6);
		end else if (d2_s6 >= D2_W'(amb_mag_s6)) begin
			km_full = (D2_W+1)'(d2_s6 - D2_W'(amb_mag_s6));
		end else begin
			kneg_c  = 1'b1;
			km_full = (D2_W+1)'(D2_W'(amb_mag_s6) - d2_s6);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			km_s7      <= km_full[SQ_W-1:0];
			kneg_s7    <= kneg_c;
			outcome_s7 <= outcome_s6;
			d2_s7      <= d2_s6;
			adx_s7     <= adx_s6;
			ady_s7     <= ady_s6;
			negx_s7    <= negx_s6;
			negy_s7    <= negy_s6;
			x0_s7      <= x0_s6;
			y0_s7      <= y0_s6;

			geo_s8.outcome <= outcome_s7;
			geo_s8.x0      <= x0_s7;
			geo_s8.y0      <= y0_s7;
			geo_s8.adx     <= adx_s7;
			geo_s8.ady     <= ady_s7;
			geo_s8.negx    <= negx_s7;
			geo_s8.negy    <= negy_s7;
			geo_s8.kneg    <= kneg_s7;
			geo_s8.km      <= km_s7;
			geo_s8.d2      <= d2_s7;
		end
	end

	cpi_sqrt #(.IN_W(QQ_W), .TAG_W($bits(geo_t))) u_sqrt (
		.clk(clk), .arst_n(arst_n), .en(adv),
		.in_valid(v_s8), .radicand(qq), .in_tag(geo_s8),
		.out_valid(sq_v), .root(sq_root), .out_tag(sq_tag));

	cpi_mul #(.A_W(CW), .B_W(SQ_W)) u_mul_t1x (
		.clk(clk), .en(adv), .a(sq_tag.adx), .b(sq_tag.km), .p(t1x));
	cpi_mul #(.A_W(CW), .B_W(SQ_W)) u_mul_t1y (
		.clk(clk), .en(adv), .a(sq_tag.ady), .b(sq_tag.km), .p(t1y));
	cpi_mul #(.A_W(CW), .B_W(RT_W)) u_mul_p (
		.clk(clk), .en(adv), .a(sq_tag.ady), .b(sq_root), .p(pp));
	cpi_mul #(.A_W(CW), .B_W(RT_W)) u_mul_q (
		.clk(clk), .en(adv), .a(sq_tag.adx), .b(sq_root), .p(qp));

	// Stages nine onwards follow the root; the root stages are not numbered.
	logic [MG_W:0] sum_ax, sum_ay, sum_bx, sum_by;

	assign sum_ax = sm_add(geo_s10.negx ^ geo_s10.kneg, t1x, !geo_s10.negy, pp);
	assign sum_ay = sm_add(geo_s10.negy ^ geo_s10.kneg, t1y, geo_s10.negx, qp);
	assign sum_bx = sm_add(geo_s10.negx ^ geo_s10.kneg, t1x, geo_s10.negy, pp);
	assign sum_by = sm_add(geo_s10.negy ^ geo_s10.kneg, t1y, !geo_s10.negx, qp);

	always_ff @(posedge clk) begin
		if (adv) begin
			geo_s9      <= sq_tag;
			geo_s10     <= geo_s9;

			{nax_s11, max_s11} <= sum_ax;
			{nay_s11, may_s11} <= sum_ay;
			{nbx_s11, mbx_s11} <= sum_bx;
			{nby_s11, mby_s11} <= sum_by;
			outcome_s11 <= geo_s10.outcome;
			x0_s11      <= geo_s10.x0;
			y0_s11      <= geo_s10.y0;
			d2_s11      <= geo_s10.d2;

			// Adding half the divisor rounds the quotient half away from zero.
			nax_num_s12 <= NUM_W'(max_s11) + NUM_W'(d2_s11);
			nay_num_s12 <= NUM_W'(may_s11) + NUM_W'(d2_s11);
			nbx_num_s12 <= NUM_W'(mbx_s11) + NUM_W'(d2_s11);
			nby_num_s12 <= NUM_W'(mby_s11) + NUM_W'(d2_s11);
			den_s12     <= {d2_s11, 1'b0};
			nax_s12     <= nax_s11;
			nay_s12     <= nay_s11;
			nbx_s12     <= nbx_s11;
			nby_s12     <= nby_s11;
			outcome_s12 <= outcome_s11;
			x0_s12      <= x0_s11;
			y0_s12      <= y0_s11;
		end
	end

	dtag_t dtag_in;

	assign dtag_in.outcome = outcome_s12;
	assign dtag_in.x0      = x0_s12;
	assign dtag_in.y0      = y0_s12;
	assign dtag_in.neg     = nax_s12;

	cpi_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .QUO_W(CW), .TAG_W($bits(dtag_t))) u_div_ax (
		.clk(clk), .arst_n(arst_n), .en(adv), .in_valid(v_s12),
		.num(nax_num_s12), .den(den_s12), .in_tag(dtag_in),
		.out_valid(dv_v), .quotient(q_ax), .big(big_ax), .out_tag(dtag));
	cpi_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .QUO_W(CW), .TAG_W(1)) u_div_ay (
		.clk(clk), .arst_n(arst_n), .en(adv), .in_valid(v_s12),
		.num(nay_num_s12), .den(den_s12), .in_tag(nay_s12),
		.out_valid(dv1_v), .quotient(q_ay), .big(big_ay), .out_tag(neg_ay));
	cpi_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .QUO_W(CW), .TAG_W(1)) u_div_bx (
		.clk(clk), .arst_n(arst_n), .en(adv), .in_valid(v_s12),
		.num(nbx_num_s12), .den(den_s12), .in_tag(nbx_s12),
		.out_valid(dv2_v), .quotient(q_bx), .big(big_bx), .out_tag(neg_bx));
	cpi_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .QUO_W(CW), .TAG_W(1)) u_div_by (
		.clk(clk), .arst_n(arst_n), .en(adv), .in_valid(v_s12),
		.num(nby_num_s12), .den(den_s12), .in_tag(nby_s12),
		.out_valid(dv3_v), .quotient(q_by), .big(big_by), .out_tag(neg_by));

	// Points are reported only for crossing circles.
	always_comb begin
		res_user = dtag.outcome;
		res_data = '0;
		if (dtag.outcome == OUT_CROSSING) begin
			res_data = OUT_PAD'({
				place(dtag.y0, neg_by, big_by, q_by),
				place(dtag.x0, neg_bx, big_bx, q_bx),
				place(dtag.y0, neg_ay, big_ay, q_ay),
				place(dtag.x0, dtag.neg, big_ax, q_ax)});
		end
	end

	// Output register with one spare entry behind it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			sk_v_q  <= 1'b0;
		end else if (!out_v_q || m_axis_tready) begin
			if (sk_v_q) begin
				out_v_q <= 1'b1;
				sk_v_q  <= 1'b0;
			end else begin
				out_v_q <= dv_v;
			end
		end else if (dv_v && !sk_v_q) begin
			sk_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || m_axis_tready) begin
			if (sk_v_q) begin
				out_data_q <= sk_data_q;
				out_user_q <= sk_user_q;
			end else begin
				out_data_q <= res_data;
				out_user_q <= res_user;
			end
		end else if (!sk_v_q) begin
			sk_data_q <= res_data;
			sk_user_q <= res_user;
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_user_q;

	a_spare_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		sk_v_q |-> out_v_q)
		else $error("spare entry holds a request while the output register is empty");

	a_no_points_unless_crossing: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && out_user_q != OUT_CROSSING) |-> (out_data_q == '0))
		else $error("points reported for circles that do not cross");

	a_stall_fills_spare: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && !m_axis_tready && dv_v && !sk_v_q) |=> sk_v_q)
		else $error("request from the pipeline was not caught during an output stall");

	a_lanes_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		dv_v == dv1_v && dv_v == dv2_v && dv_v == dv3_v)
		else $error("divider lanes out of step");

endmodule

`default_nettype wire

### rtl/core/cpi_mul.sv
// Two-stage multiplier: registered partial products, then a registered sum.
`default_nettype none

module cpi_mul #(
	parameter int unsigned A_W = 32,
	parameter int unsigned B_W = 32
) (
	input  wire logic                 clk,
	input  wire logic                 en,
	input  wire logic [A_W-1:0]       a,
	input  wire logic [B_W-1:0]       b,
	output logic      [A_W+B_W-1:0]   p
);
	import cpi_pkg::*;

	localparam int unsigned NA = (A_W + MUL_CHUNK - 1) / MUL_CHUNK;
	localparam int unsigned NB = (B_W + MUL_CHUNK - 1) / MUL_CHUNK;
	localparam int unsigned AP = NA * MUL_CHUNK;
	localparam int unsigned BP = NB * MUL_CHUNK;

	logic [AP-1:0]            a_pad;
	logic [BP-1:0]            b_pad;
	logic [2*MUL_CHUNK-1:0]   pp_s1 [NA][NB];
	logic [AP+BP-1:0]         acc;
	logic [A_W+B_W-1:0]       p_s2;

	assign a_pad = AP'(a);
	assign b_pad = BP'(b);

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NA; i++) begin
				for (int j = 0; j < NB; j++) begin
					pp_s1[i][j] <= a_pad[i*MUL_CHUNK +: MUL_CHUNK] *
						b_pad[j*MUL_CHUNK +: MUL_CHUNK];
				end
			end
		end
	end

	always_comb begin
		acc = '0;
		for (int i = 0; i < NA; i++) begin
			for (int j = 0; j < NB; j++) begin
				acc = acc + ((AP+BP)'(pp_s1[i][j]) << (MUL_CHUNK * (i + j)));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s2 <= acc[A_W+B_W-1:0];
		end
	end

	assign p = p_s2;

endmodule

`default_nettype wire

### rtl/core/cpi_sqrt.sv
// Pipelined integer square root: an input register, then one root bit resolved per stage.
`default_nettype none

module cpi_sqrt #(
	parameter int unsigned IN_W  = 128,
	parameter int unsigned TAG_W = 1
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 en,
	input  wire logic                 in_valid,
	input  wire logic [IN_W-1:0]      radicand,
	input  wire logic [TAG_W-1:0]     in_tag,
	output logic                      out_valid,
	output logic      [IN_W/2-1:0]    root,
	output logic      [TAG_W-1:0]     out_tag
);
	localparam int unsigned RT_W  = IN_W / 2;
	localparam int unsigned REM_W = RT_W + 2;

	logic              vld_s  [RT_W+1];
	logic [REM_W-1:0]  rem_s  [RT_W+1];
	logic [RT_W-1:0]   root_s [RT_W+1];
	logic [IN_W-1:0]   rad_s  [RT_W+1];
	logic [TAG_W-1:0]  tag_s  [RT_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= '0;
			root_s[0] <= '0;
			rad_s[0]  <= radicand;
			tag_s[0]  <= in_tag;
		end
	end

	for (genvar k = 0; k < RT_W; k++) begin : g_step
		logic [REM_W+1:0] cur;
		logic [REM_W+1:0] trial;
		logic             take;

		// Bring down the next two radicand bits and try appending a one.
		assign cur   = {rem_s[k], rad_s[k][IN_W-1 -: 2]};
		assign trial = (REM_W+2)'({root_s[k], 2'b01});
		assign take  = cur >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1]  <= take ? REM_W'(cur - trial) : REM_W'(cur);
				root_s[k+1] <= {root_s[k][RT_W-2:0], take};
				rad_s[k+1]  <= rad_s[k] << 2;
				tag_s[k+1]  <= tag_s[k];
			end
		end
	end

	assign out_valid = vld_s[RT_W];
	assign root      = root_s[RT_W];
	assign out_tag   = tag_s[RT_W];

endmodule

`default_nettype wire

### rtl/core/cpi_div.sv
// Pipelined restoring divider with a flag for quotients beyond its width.
`default_nettype none

module cpi_div #(
	parameter int unsigned NUM_W = 98,
	parameter int unsigned DEN_W = 66,
	parameter int unsigned QUO_W = 32,
	parameter int unsigned TAG_W = 1
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 en,
	input  wire logic                 in_valid,
	input  wire logic [NUM_W-1:0]     num,
	input  wire logic [DEN_W-1:0]     den,
	input  wire logic [TAG_W-1:0]     in_tag,
	output logic                      out_valid,
	output logic      [QUO_W-1:0]     quotient,
	output logic                      big,
	output logic      [TAG_W-1:0]     out_tag
);
	localparam int unsigned XW = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;

	logic              vld_s [QUO_W+1];
	logic [XW-1:0]     rem_s [QUO_W+1];
	logic [DEN_W-1:0]  den_s [QUO_W+1];
	logic [QUO_W-1:0]  quo_s [QUO_W+1];
	logic              big_s [QUO_W+1];
	logic [TAG_W-1:0]  tag_s [QUO_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_valid;
		end
	end

	// The overflow test first: once it fails, every step keeps the
	// remainder below twice its trial divisor.
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= XW'(num);
			den_s[0] <= den;
			quo_s[0] <= '0;
			big_s[0] <= XW'(num) >= (XW'(den) << QUO_W);
			tag_s[0] <= in_tag;
		end
	end

	for (genvar k = 0; k < QUO_W; k++) begin : g_step
		localparam int unsigned SH = QUO_W - 1 - k;
		logic [XW-1:0] sub;
		logic          take;

		assign sub  = XW'(den_s[k]) << SH;
		assign take = rem_s[k] >= sub;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= take ? rem_s[k] - sub : rem_s[k];
				den_s[k+1] <= den_s[k];
				quo_s[k+1] <= {quo_s[k][QUO_W-2:0], take};
				big_s[k+1] <= big_s[k];
				tag_s[k+1] <= tag_s[k];
			end
		end
	end

	assign out_valid = vld_s[QUO_W];
	assign quotient  = quo_s[QUO_W];
	assign big       = big_s[QUO_W];
	assign out_tag   = tag_s[QUO_W];

endmodule

`default_nettype wire

### test/tb.sv
// Self-checking testbench for the circle pair intersection unit.
`timescale 1ns / 100ps
`default_nettype none

module tb;
	import cpi_pkg::*;

	localparam int CW = 32;
	localparam int HOLD_CYCLES = 400;
	localparam int TAIL_CYCLES = 150;

	typedef struct packed {
		logic [CW-2:0] r1;
		logic [CW-1:0] y1;
		logic [CW-1:0] x1;
		logic [CW-2:0] r0;
		logic [CW-1:0] y0;
		logic [CW-1:0] x0;
	} circles_t;

	typedef struct {
		outcome_t      oc;
		logic [CW-1:0] ax, ay, bx, by;
	} crossing_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [191:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [127:0] m_axis_tdata;
	logic [1:0] m_axis_tuser;

	bit calm = 0;
	bit hold_req = 0;
	int outcome_seen [3] = '{0, 0, 0};

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	circle_pair_intersection_unit uut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
	);

	// Signed sum of two sign/magnitude values; the sign is returned in bit 128.
	function automatic logic [128:0] signed_sum(bit na, logic [127:0] ma, bit nb,
			logic [127:0] mb);
		if (na == nb) return {na, ma + mb};
		if (ma >= mb) return {na, ma - mb};
		return {nb, mb - ma};
	endfunction

	// Base plus the quotient rounded half away from zero, saturated to the coordinate range.
	function automatic logic [CW-1:0] place_point(longint base, logic [128:0] sm,
			logic [127:0] d2);
		logic [127:0] q;
		longint qv, v;
		q = (sm[127:0] + d2) / (d2 << 1);
		qv = (q >= 128'h4000_0000_0000_0000) ? 64'sh4000_0000_0000_0000 : longint'(q[63:0]);
		v = sm[128] ? base - qv : base + qv;
		if (v > 64'sd2147483647) v = 64'sd2147483647;
		if (v < -64'sd2147483648) v = -64'sd2147483648;
		return v[CW-1:0];
	endfunction

	function automatic logic [127:0] isqrt(logic [127:0] n);
		logic [127:0] r, c;
		r = '0;
		for (int b = 63; b >= 0; b--) begin
			c = r | (128'd1 << b);
			if (c * c <= n) r = c;
		end
		return r;
	endfunction

	function automatic crossing_t predict_crossing(circles_t c);
		crossing_t res;
		longint x0, y0, x1, y1, dx, dy;
		logic [127:0] adx, ady, r0, r1, sum, dr, d2, s2, dr2, qq, s, a2, b2, km, t;
		logic [127:0] t1x, t1y, p, q;
		bit kneg, n1x, n1y, np, nq;
		x0 = longint'($signed(c.x0)); y0 = longint'($signed(c.y0));
		x1 = longint'($signed(c.x1)); y1 = longint'($signed(c.y1));
		r0 = 128'(c.r0); r1 = 128'(c.r1);
		dx = x1 - x0; dy = y1 - y0;
		adx = 128'(dx < 0 ? -dx : dx);
		ady = 128'(dy < 0 ? -dy : dy);
		sum = r0 + r1;
		dr = r0 > r1 ? r0 - r1 : r1 - r0;
		res = '{OUT_APART, '0, '0, '0, '0};
		d2 = adx * adx + ady * ady;
		s2 = sum * sum;
		if (d2 > s2) return res;
		dr2 = dr * dr;
		if (d2 <= dr2) begin
			res.oc = OUT_CONTAINED;
			return res;
		end
		qq = 128'((d2 - dr2) & 128'hFFFF_FFFF_FFFF_FFFF) * 128'((s2 - d2) & 128'hFFFF_FFFF_FFFF_FFFF);
		s = isqrt(qq);
		a2 = r0 * r0;
		b2 = r1 * r1;
		if (a2 >= b2) begin
			kneg = 0; km = d2 + (a2 - b2);
		end else begin
			t = b2 - a2;
			if (d2 >= t) begin
				kneg = 0; km = d2 - t;
			end else begin
				kneg = 1; km = t - d2;
			end
		end
		km = km & 128'hFFFF_FFFF_FFFF_FFFF;
		t1x = adx * km; n1x = (dx < 0) ^ kneg;
		t1y = ady * km; n1y = (dy < 0) ^ kneg;
		p = ady * s; np = dy < 0;
		q = adx * s; nq = dx < 0;
		res.oc = OUT_CROSSING;
		res.ax = place_point(x0, signed_sum(n1x, t1x, !np, p), d2);
		res.ay = place_point(y0, signed_sum(n1y, t1y, nq, q), d2);
		res.bx = place_point(x0, signed_sum(n1x, t1x, np, p), d2);
		res.by = place_point(y0, signed_sum(n1y, t1y, !nq, q), d2);
		return res;
	endfunction

	class crossing_board;
		crossing_t pending [$];
		int mismatches = 0;
		int checked = 0;

		function void note_request(circles_t c);
			pending = {pending, predict_crossing(c)};
		endfunction

		function void check_result(logic [1:0] oc, logic [127:0] pts);
			crossing_t e;
			checked++;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected result outcome %0d", $realtime, oc);
				return;
			end
			e = pending.pop_front();
			if (oc !== e.oc || pts !== {e.by, e.bx, e.ay, e.ax}) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: expected %0d a(%h,%h) b(%h,%h), got %0d a(%h,%h) b(%h,%h)",
						$realtime, e.oc, e.ax, e.ay, e.bx, e.by, oc,
						pts[31:0], pts[63:32], pts[95:64], pts[127:96]);
			end
		endfunction
	endclass

	crossing_board board = new();

	always @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready)
			board.note_request(circles_t'(s_axis_tdata[189:0]));
		if (m_axis_tvalid && m_axis_tready) begin
			board.check_result(m_axis_tuser, m_axis_tdata);
			if (m_axis_tuser < 3) outcome_seen[m_axis_tuser]++;
		end
	end

	// Result side: random stalls, one long hold on request, none near the end.
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 0;
				m_axis_tready <= 1'b1;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				n = $urandom_range(1, 11);
				m_axis_tready <= 1'b0;
				repeat (n) @(posedge clk);
				m_axis_tready <= 1'b1;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	task automatic send_pair(circles_t c);
		int n;
		s_axis_tdata <= {2'b00, c};
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		if (!calm && $urandom_range(0, 5) == 0) begin
			n = $urandom_range(1, 11);
			s_axis_tvalid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic send_geom(int x0, int y0, int r0, int x1, int y1, int r1);
		circles_t c;
		c.x0 = x0; c.y0 = y0; c.r0 = r0[CW-2:0];
		c.x1 = x1; c.y1 = y1; c.r1 = r1[CW-2:0];
		send_pair(c);
	endtask

	function automatic circles_t random_pair();
		circles_t c;
		int unsigned k, sum, span;
		logic [31:0] dx, dy;
		logic [191:0] raw;
		if ($urandom_range(0, 4) == 0) begin
			raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
			c = raw[189:0];
			return c;
		end
		// Well-formed pair of near circles at a random scale, mostly crossing.
		k = $urandom_range(2, 29);
		c.x0 = $urandom; c.y0 = $urandom;
		c.r0 = 31'($urandom & ((1 << k) - 1));
		c.r1 = 31'($urandom & ((1 << k) - 1));
		sum = c.r0 + c.r1;
		span = sum < 32'h7fff_ffff ? sum + 1 : 32'h7fff_ffff;
		dx = $urandom_range(0, span);
		dy = $urandom_range(0, span / 2);
		if ($urandom_range(0, 1)) dx = -dx;
		if ($urandom_range(0, 1)) dy = -dy;
		if ($urandom_range(0, 1)) begin
			c.x1 = c.x0 + dx; c.y1 = c.y0 + dy;
		end else begin
			c.x1 = c.x0 + dy; c.y1 = c.y0 + dx;
		end
		return c;
	endfunction

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed cases: apart, contained, coincident, touching, crossing, extremes.
		send_geom(0, 0, 32'h10000, 32'h50000, 0, 32'h10000);
		send_geom(0, 0, 32'h50000, 32'h10000, 0, 32'h10000);
		send_geom(32'h30000, 32'h30000, 32'h20000, 32'h30000, 32'h30000, 32'h20000);
		send_geom(0, 0, 32'h10000, 32'h30000, 0, 32'h20000);
		send_geom(0, 0, 32'h30000, 32'h10000, 0, 32'h20000);
		send_geom(0, 0, 32'h30000, 32'h40000, 0, 32'h20000);
		send_geom(0, 0, 32'h30000, 32'h30000, 32'h30000, 32'h30000);
		send_geom(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
			32'h80000000, 32'h80000000, 32'h7fffffff);
		send_geom(32'h80000000, 32'h80000000, 32'h7fffffff,
			32'h7fffffff, 32'h80000000, 32'h7fffffff);
		send_geom(32'h7fff0000, 0, 32'h40000000, 32'h7fff0000, 32'h40000000, 32'h10000000);
		send_geom(0, 0, 0, 0, 0, 0);
		send_geom(0, 0, 0, 1, 0, 0);
		send_geom(0, 0, 1, 1, 1, 1);
		send_geom(-5, 7, 3, -2, 11, 4);
		send_geom(0, 0, 32'h7fffffff, 0, 0, 0);
		send_geom(32'h80000000, 0, 32'h7fffffff, 32'h7fffffff, 0, 32'h7fffffff);
		send_geom(32'hffffffff, 32'hffffffff, 32'h7fffffff, 0, 0, 32'h7ffffffe);
		send_geom(100, -100, 150, -100, 100, 150);

		for (int i = 0; i < 1300; i++) begin
			if (i == 400) hold_req = 1;
			if (i == 700) begin
				s_axis_tvalid <= 1'b0;
				while (board.pending.size() != 0) @(posedge clk);
			end
			if (i == 1100) calm = 1;
			send_pair(random_pair());
		end
		s_axis_tvalid <= 1'b0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("tb: checked %0d results: %0d apart, %0d contained, %0d crossing",
			board.checked, outcome_seen[0], outcome_seen[1], outcome_seen[2]);
		if (board.mismatches == 0 && board.pending.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin
		#5ms;
		$display("tb: failure");
		$finish;
	end
endmodule

`default_nettype wire
